>>> rtl/mpp_pkg.sv
package mpp_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS = 22;
  localparam int PIXEL_BITS      = 16;
  localparam int LON_W           = 31;
  localparam int LAT_W           = 30;
  localparam int WIN_W           = 14;

  // Rotation and logarithm chains
  localparam int CORDIC_STEPS = 30;
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);
  localparam int LOG_FRAC     = 28;
  localparam int LIDX_W       = $clog2(LOG_FRAC);
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int OP_W         = 34;
  localparam int MANT_W       = 31;
  localparam int EXP_W        = 6;
  localparam int P_W          = EXP_W + LOG_FRAC + 2;

  // Division lanes
  localparam int NUM_W     = 52;
  localparam int DEN_W     = P_W + 1;
  localparam int R_W       = NUM_W;
  localparam int Q_W       = PIXEL_BITS;
  localparam int DIV_IDX_W = $clog2(PIXEL_BITS);

  // Ordinate pipeline depth: front, rotation, two log setup stages, squaring, difference
  localparam int MERC_LAT = 1 + CORDIC_STEPS + 2 + LOG_FRAC + 1;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [26:0] DEG_TO_RAD  = 27'd74961321;
  localparam logic [LAT_W-1:0] LAT_LIMIT =
    LAT_W'((85 << ANGLE_FRAC_BITS) + ((5 << ANGLE_FRAC_BITS) / 100));

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  function automatic logic [31:0] atan_q30(input logic [CIDX_W-1:0] idx);
    return ATAN_Q30[idx];
  endfunction

  typedef enum logic [2:0] {
    REG_LON_LEFT   = 3'd0,
    REG_LON_RIGHT  = 3'd1,
    REG_LAT_BOTTOM = 3'd2,
    REG_LAT_TOP    = 3'd3,
    REG_WIN_WIDTH  = 3'd4,
    REG_WIN_HEIGHT = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_ITEM,
    KIND_BOT,
    KIND_TOP
  } item_kind_t;

  typedef enum logic [1:0] {
    CAL_RUN,
    CAL_BOT,
    CAL_TOP,
    CAL_WAIT
  } cal_state_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [MANT_W-1:0]   ma;
    logic [MANT_W-1:0]   mb;
    logic [LOG_FRAC-1:0] fa;
    logic [LOG_FRAC-1:0] fb;
    logic [EXP_W-1:0]    ea;
    logic [EXP_W-1:0]    eb;
  } log_t;

  typedef struct packed {
    item_kind_t              kind;
    logic                    ring;
    logic signed [NUM_W-1:0] numx;
  } side_t;

  typedef struct packed {
    logic [R_W-1:0]   r;
    logic [DEN_W-1:0] d;
    logic [Q_W-1:0]   q;
    logic             pos;
    logic             big;
    logic             zero;
  } div_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pix_y;
    logic signed [PIXEL_BITS-1:0] pix_x;
    logic                         ring;
    logic                         clip;
  } out_t;

endpackage

>>> rtl/mercator_point_to_pixel_top.sv
// Web Mercator vertex projector.
// Input channel s_*: one vertex per beat, tdata holds lon (bits 30:0) and
// lat (bits 60:31), both degrees with 22 fraction bits; tlast marks a ring end.
// Output channel m_*: tdata holds pix_x (15:0) and pix_y (31:16), saturated
// signed pixels; tlast copies the ring end; tuser is the clip flag.
// Config port: cfg_we writes cfg_data into register cfg_index (0 lon_left,
// 1 lon_right, 2 lat_bottom, 3 lat_top, 4 win_width, 5 win_height).
// Throughput is one vertex per cycle unless calibration or a full output
// buffer holds input; a beat reaches m_tvalid through the 30-cell rotation
// chain, the 28-cell log squaring chain and the 16-cell divider rows.
// After reset, and after any write of lat_bottom or lat_top, s_tready stays
// low while the two box latitudes run through the ordinate chain and their
// results are latched.
// A stalled receiver is absorbed by a two-entry output buffer; once it is
// full the whole pipeline holds and s_tready drops.
module mercator_point_to_pixel_top import mpp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // lon[30:0], lat[60:31], zero pad
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // pix_x[15:0], pix_y[31:16]
  output logic             m_tlast,
  output logic             m_tuser,   // clipped
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [LON_W-1:0] cfg_data
);

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    zero;
  } prep_t;

  // Configuration registers
  logic signed [LON_W-1:0] lon_left;
  logic signed [LON_W-1:0] lon_right;
  logic signed [LAT_W-1:0] lat_bottom;
  logic signed [LAT_W-1:0] lat_top;
  logic [WIN_W-1:0]        win_width;
  logic [WIN_W-1:0]        win_height;

  // Box ordinates
  logic signed [P_W-1:0]   pb;
  logic signed [P_W-1:0]   pt;
  logic signed [DEN_W-1:0] dx_r;
  logic signed [DEN_W-1:0] dy_r;

  // Calibration sequencer
  cal_state_t state;
  cal_state_t state_next;
  logic       cal_need;
  logic       cal_clear;
  logic [1:0] pend;
  logic       inject;
  item_kind_t inj_kind;
  logic       lat_write;
  logic       capture;

  logic adv;
  logic s_acc;

  logic signed [LON_W-1:0] s_lon;
  logic signed [LAT_W-1:0] s_lat;
  logic signed [LON_W:0]   dlon_c;

  logic                    s0_vld;
  logic signed [LAT_W-1:0] s0_lat;
  item_kind_t              s0_kind;
  logic                    s0_ring;
  logic signed [LON_W:0]   s0_dlon;
  logic signed [NUM_W-1:0] numx_c;
  side_t                   s0_side;

  logic                  mo_vld;
  side_t                 mo_side;
  logic signed [P_W-1:0] mo_p;

  logic                  y1_vld;
  side_t                 y1_side;
  logic signed [P_W:0]   y1_dyn;
  logic                    y2_vld;
  side_t                   y2_side;
  logic signed [NUM_W-1:0] y2_numy;
  logic                    d0_vld;
  logic                    d0_ring;
  prep_t                   d0_x;
  prep_t                   d0_y;

  logic pv [Q_W+1];
  logic pr [Q_W+1];
  div_t dvx [Q_W+1];
  div_t dvy [Q_W+1];

  logic [Q_W:0] fx_c;
  logic [Q_W:0] fy_c;
  out_t         fo_c;

  // Output buffer
  out_t       obuf [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  function automatic prep_t norm_sign(input logic signed [NUM_W-1:0] num,
                                      input logic signed [DEN_W-1:0] den);
    prep_t p;
    p.zero = (den == '0);
    if (den[DEN_W-1]) begin
      p.num = -num;
      p.den = -den;
    end else begin
      p.num = num;
      p.den = den;
    end
    return p;
  endfunction

  function automatic div_t div_init(input prep_t p);
    div_t d;
    d.pos  = !p.num[NUM_W-1] && (p.num != '0);
    d.r    = d.pos ? R_W'(p.num - NUM_W'(1)) : R_W'(-p.num);
    d.d    = DEN_W'(p.den);
    d.q    = '0;
    d.big  = (R_W + 2)'(d.r) >= ((R_W + 2)'(d.d) << PIXEL_BITS);
    d.zero = p.zero;
    return d;
  endfunction

  function automatic logic [Q_W:0] pix_finish(input div_t d);
    logic [Q_W-1:0] v;
    logic           c;
    c = 1'b0;
    if (d.zero) begin
      v = '0;
      c = 1'b1;
    end else if (d.big) begin
      v = d.pos ? Q_MAX : Q_MIN;
      c = 1'b1;
    end else if (d.pos) begin
      if (d.q[Q_W-1]) begin
        v = Q_MAX;
        c = 1'b1;
      end else begin
        v = d.q;
      end
    end else begin
      if (d.q[Q_W-1] && (d.q[Q_W-2:0] != '0)) begin
        v = Q_MIN;
        c = 1'b1;
      end else begin
        v = -d.q;
      end
    end
    return {c, v};
  endfunction

  // Configuration writes
  assign lat_write = cfg_we && ((cfg_index == REG_LAT_BOTTOM) || (cfg_index == REG_LAT_TOP));

  always_ff @(posedge clk) begin
    if (rst) begin
      lon_left   <= -(LON_W'(180) << ANGLE_FRAC_BITS);
      lon_right  <= LON_W'(180) << ANGLE_FRAC_BITS;
      lat_bottom <= -(LAT_W'(85) << ANGLE_FRAC_BITS);
      lat_top    <= LAT_W'(85) << ANGLE_FRAC_BITS;
      win_width  <= WIN_W'(1024);
      win_height <= WIN_W'(1024);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_LON_LEFT:   lon_left   <= cfg_data;
        REG_LON_RIGHT:  lon_right  <= cfg_data;
        REG_LAT_BOTTOM: lat_bottom <= cfg_data[LAT_W-1:0];
        REG_LAT_TOP:    lat_top    <= cfg_data[LAT_W-1:0];
        REG_WIN_WIDTH:  win_width  <= cfg_data[WIN_W-1:0];
        REG_WIN_HEIGHT: win_height <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the pipeline only when the output buffer is full and not draining
  assign adv      = !((cnt == 2'd2) && !m_tready);
  assign s_tready = adv && (state == CAL_RUN) && !cal_need;
  assign s_acc    = s_tvalid && s_tready;

  // Sequencer: push both box latitudes through the ordinate chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CAL_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    inject     = 1'b0;
    inj_kind   = KIND_ITEM;
    cal_clear  = 1'b0;
    unique case (state)
      CAL_RUN: begin
        if (cal_need) begin
          state_next = CAL_BOT;
          cal_clear  = 1'b1;
        end
      end
      CAL_BOT: begin
        if (adv) begin
          inject     = 1'b1;
          inj_kind   = KIND_BOT;
          state_next = CAL_TOP;
        end
      end
      CAL_TOP: begin
        if (adv) begin
          inject     = 1'b1;
          inj_kind   = KIND_TOP;
          state_next = CAL_WAIT;
        end
      end
      CAL_WAIT: begin
        if (pend == 2'd0) begin
          if (cal_need) begin
            state_next = CAL_BOT;
            cal_clear  = 1'b1;
          end else begin
            state_next = CAL_RUN;
          end
        end
      end
      default: state_next = CAL_RUN;
    endcase
  end

  assign capture = adv && mo_vld && (mo_side.kind != KIND_ITEM);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_need <= 1'b1;
      pend     <= 2'd0;
    end else begin
      if (lat_write) begin
        cal_need <= 1'b1;
      end else if (cal_clear) begin
        cal_need <= 1'b0;
      end
      pend <= pend + {1'b0, inject} - {1'b0, capture};
    end
  end

  // Input stage
  assign s_lon  = s_tdata[LON_W-1:0];
  assign s_lat  = s_tdata[LON_W+LAT_W-1:LON_W];
  assign dlon_c = s_lon - lon_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= s_acc || inject;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_kind <= inject ? inj_kind : KIND_ITEM;
      s0_ring <= s_tlast;
      s0_dlon <= dlon_c;
      if (inject) begin
        s0_lat <= (inj_kind == KIND_BOT) ? lat_bottom : lat_top;
      end else begin
        s0_lat <= s_lat;
      end
    end
  end

  assign numx_c       = s0_dlon * $signed({1'b0, win_width});
  assign s0_side.kind = s0_kind;
  assign s0_side.ring = s0_ring;
  assign s0_side.numx = numx_c;

  mpp_merc u_merc (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s0_vld),
    .in_lat   (s0_lat),
    .in_side  (s0_side),
    .out_vld  (mo_vld),
    .out_side (mo_side),
    .out_p    (mo_p)
  );

  // Latch box ordinates and their spans
  always_ff @(posedge clk) begin
    if (capture) begin
      if (mo_side.kind == KIND_BOT) begin
        pb <= mo_p;
      end else begin
        pt <= mo_p;
      end
    end
    dy_r <= pt - pb;
    dx_r <= lon_right - lon_left;
  end

  // Offset from the bottom ordinate, scale by the height, normalize signs
  always_ff @(posedge clk) begin
    if (rst) begin
      y1_vld <= 1'b0;
      y2_vld <= 1'b0;
      d0_vld <= 1'b0;
    end else if (adv) begin
      y1_vld <= mo_vld && (mo_side.kind == KIND_ITEM);
      y2_vld <= y1_vld;
      d0_vld <= y2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_side <= mo_side;
      y1_dyn  <= mo_p - pb;
      y2_side <= y1_side;
      y2_numy <= y1_dyn * $signed({1'b0, win_height});
      d0_ring <= y2_side.ring;
      d0_x    <= norm_sign(y2_side.numx, dx_r);
      d0_y    <= norm_sign(y2_numy, dy_r);
    end
  end

  // Divider rows, one quotient bit per cell
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) pv[k] <= 1'b0;
    end else if (adv) begin
      pv[0] <= d0_vld;
      for (int k = 1; k <= Q_W; k++) pv[k] <= pv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0]  <= d0_ring;
      dvx[0] <= div_init(d0_x);
      dvy[0] <= div_init(d0_y);
      for (int k = 1; k <= Q_W; k++) pr[k] <= pr[k-1];
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    mpp_div_cell u_cell_x (
      .clk   (clk),
      .en    (adv),
      .step  (DIV_IDX_W'(Q_W - 1 - k)),
      .in_d  (dvx[k]),
      .out_d (dvx[k+1])
    );
    mpp_div_cell u_cell_y (
      .clk   (clk),
      .en    (adv),
      .step  (DIV_IDX_W'(Q_W - 1 - k)),
      .in_d  (dvy[k]),
      .out_d (dvy[k+1])
    );
  end

  // Round toward the pixel, saturate, merge clip flags
  always_comb begin
    fx_c       = pix_finish(dvx[Q_W]);
    fy_c       = pix_finish(dvy[Q_W]);
    fo_c.pix_x = fx_c[Q_W-1:0];
    fo_c.pix_y = fy_c[Q_W-1:0];
    fo_c.ring  = pr[Q_W];
    fo_c.clip  = fx_c[Q_W] || fy_c[Q_W];
  end

  // Output buffer
  assign push = pv[Q_W] && adv;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wp] <= fo_c;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {obuf[rp].pix_y, obuf[rp].pix_x};
  assign m_tlast  = obuf[rp].ring;
  assign m_tuser  = obuf[rp].clip;

endmodule

>>> rtl/mpp_cordic_cell.sv
module mpp_cordic_cell import mpp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [CIDX_W-1:0] step,
  input  cordic_t           in_c,
  output cordic_t           out_c
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;
  cordic_t                nxt;

  // Rotate toward zero residual angle
  always_comb begin
    dx  = in_c.y >>> step;
    dy  = in_c.x >>> step;
    ang = Z_W'(atan_q30(step));
    if (!in_c.z[Z_W-1]) begin
      nxt.x = in_c.x - dx;
      nxt.y = in_c.y + dy;
      nxt.z = in_c.z - ang;
    end else begin
      nxt.x = in_c.x + dx;
      nxt.y = in_c.y - dy;
      nxt.z = in_c.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= nxt;
    end
  end

endmodule

>>> rtl/mpp_log_cell.sv
module mpp_log_cell import mpp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [LIDX_W-1:0] step,
  input  log_t              in_l,
  output log_t              out_l
);

  logic [2*MANT_W-1:0] sq_a;
  logic [2*MANT_W-1:0] sq_b;
  logic [MANT_W:0]     ta;
  logic [MANT_W:0]     tb;
  logic [LIDX_W-1:0]   pos;
  log_t                nxt;

  // Square both mantissas; an overflow past two yields the next fraction bit
  always_comb begin
    sq_a = in_l.ma * in_l.ma;
    sq_b = in_l.mb * in_l.mb;
    ta   = sq_a[2*MANT_W-1:MANT_W-1];
    tb   = sq_b[2*MANT_W-1:MANT_W-1];
    pos  = LIDX_W'(LOG_FRAC - 1) - step;
    nxt  = in_l;
    if (ta[MANT_W]) begin
      nxt.ma      = ta[MANT_W:1];
      nxt.fa[pos] = 1'b1;
    end else begin
      nxt.ma = ta[MANT_W-1:0];
    end
    if (tb[MANT_W]) begin
      nxt.mb      = tb[MANT_W:1];
      nxt.fb[pos] = 1'b1;
    end else begin
      nxt.mb = tb[MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_l <= nxt;
    end
  end

endmodule

>>> rtl/mpp_div_cell.sv
module mpp_div_cell import mpp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_IDX_W-1:0] step,
  input  div_t                 in_d,
  output div_t                 out_d
);

  logic [R_W:0] sub;
  logic [R_W:0] trial;
  div_t         nxt;

  // One restoring step: try the shifted divisor, keep it if it fits
  always_comb begin
    sub   = (R_W + 1)'(in_d.d) << step;
    trial = {1'b0, in_d.r} - sub;
    nxt   = in_d;
    if (!trial[R_W]) begin
      nxt.r       = trial[R_W-1:0];
      nxt.q[step] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

>>> rtl/mpp_merc.sv
module mpp_merc import mpp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [LAT_W-1:0] in_lat,
  input  side_t                   in_side,
  output logic                    out_vld,
  output side_t                   out_side,
  output logic signed [P_W-1:0]   out_p
);

  localparam logic signed [XY_W:0] ONE_Q30 = (XY_W + 1)'(1) << 30;

  logic        vld_q  [MERC_LAT];
  logic        neg_q  [MERC_LAT];
  side_t       side_q [MERC_LAT];

  logic              neg_c;
  logic [LAT_W-1:0]  mag_c;
  logic [LAT_W-1:0]  magc_c;
  logic [LAT_W+26:0] prod_c;
  cordic_t           c0_c;
  cordic_t           cc [CORDIC_STEPS+1];

  logic signed [XY_W:0] sa_c;
  logic [OP_W-1:0]      ua_c;
  logic [OP_W-1:0]      ub_c;
  logic [OP_W-1:0]      ln_ua;
  logic [OP_W-1:0]      ln_ub;
  logic [EXP_W-1:0]     ln_ea;
  logic [EXP_W-1:0]     ln_eb;
  logic [OP_W+29:0]     sh_a;
  logic [OP_W+29:0]     sh_b;
  log_t                 lg0_c;
  log_t                 lg [LOG_FRAC+1];

  logic [EXP_W+LOG_FRAC-1:0] la_c;
  logic [EXP_W+LOG_FRAC-1:0] lb_c;
  logic signed [P_W-1:0]     p_c;

  function automatic logic [EXP_W-1:0] top_bit(input logic [OP_W-1:0] u);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 0; i < OP_W; i++) begin
      if (u[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

  // Track valid, sign and sideband alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MERC_LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_vld;
      for (int k = 1; k < MERC_LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_q[0]  <= neg_c;
      side_q[0] <= in_side;
      for (int k = 1; k < MERC_LAT; k++) begin
        neg_q[k]  <= neg_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Clamp the magnitude and convert degrees to radians
  always_comb begin
    neg_c  = in_lat[LAT_W-1];
    mag_c  = neg_c ? LAT_W'(-in_lat) : LAT_W'(in_lat);
    magc_c = (mag_c > LAT_LIMIT) ? LAT_LIMIT : mag_c;
    prod_c = magc_c * DEG_TO_RAD + ((LAT_W + 27)'(1) << (ANGLE_FRAC_BITS + 1));
    c0_c.x = XY_W'(CORDIC_GAIN);
    c0_c.y = '0;
    c0_c.z = Z_W'(prod_c >> (ANGLE_FRAC_BITS + 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc[0] <= c0_c;
    end
  end

  // Rotation chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    mpp_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (CIDX_W'(i)),
      .in_c  (cc[i]),
      .out_c (cc[i+1])
    );
  end

  // Log operands: one plus sine, and cosine; locate their top bits
  always_comb begin
    sa_c = ONE_Q30 + cc[CORDIC_STEPS].y;
    ua_c = (sa_c[XY_W] || (sa_c == '0)) ? OP_W'(1) : sa_c[OP_W-1:0];
    ub_c = (cc[CORDIC_STEPS].x[XY_W-1] || (cc[CORDIC_STEPS].x == '0)) ?
           OP_W'(1) : OP_W'(cc[CORDIC_STEPS].x);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_ua <= ua_c;
      ln_ub <= ub_c;
      ln_ea <= top_bit(ua_c);
      ln_eb <= top_bit(ub_c);
    end
  end

  // Normalize to a mantissa in one to two
  always_comb begin
    sh_a     = {ln_ua, 30'b0} >> ln_ea;
    sh_b     = {ln_ub, 30'b0} >> ln_eb;
    lg0_c.ma = sh_a[MANT_W-1:0];
    lg0_c.mb = sh_b[MANT_W-1:0];
    lg0_c.fa = '0;
    lg0_c.fb = '0;
    lg0_c.ea = ln_ea;
    lg0_c.eb = ln_eb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg[0] <= lg0_c;
    end
  end

  // Squaring chain
  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
    mpp_log_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (LIDX_W'(j)),
      .in_l  (lg[j]),
      .out_l (lg[j+1])
    );
  end

  // Difference of the two logs, sign restored
  always_comb begin
    la_c = {lg[LOG_FRAC].ea, lg[LOG_FRAC].fa};
    lb_c = {lg[LOG_FRAC].eb, lg[LOG_FRAC].fb};
    p_c  = $signed({2'b00, la_c}) - $signed({2'b00, lb_c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p <= neg_q[MERC_LAT-2] ? -p_c : p_c;
    end
  end

  assign out_vld  = vld_q[MERC_LAT-1];
  assign out_side = side_q[MERC_LAT-1];

endmodule

>>> rtl/mpp_checker.sv
module mpp_props import mpp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser,
  input logic        cfg_we,
  input logic [2:0]  cfg_index
);

  // Reset leaves no result pending and recomputes the box first
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("beat possible right after reset");

  // A new box latitude blocks input until it is recomputed
  a_lat_recal: assert property (@(posedge clk) disable iff (rst)
    cfg_we && ((cfg_index == REG_LAT_BOTTOM) || (cfg_index == REG_LAT_TOP)) |=> !s_tready)
    else $error("input taken while box latitudes are stale");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tlast, m_tuser}))
    else $error("stalled output beat changed");

endmodule

bind mercator_point_to_pixel_top mpp_props u_mpp_checker (.*);

>>> test/mpp_checker.sv
module mpp_checker import mpp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [63:0]      s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [31:0]      m_tdata,
  input  logic             m_tlast,
  input  logic             m_tuser,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [LON_W-1:0] cfg_data,
  output int               pixels_pending,
  output int               mismatches
);

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pix_x;
    logic signed [PIXEL_BITS-1:0] pix_y;
    logic                         ring;
    logic                         clip;
  } pixel_t;

  pixel_t pixel_q[$];

  // Shadow copy of the view box
  longint box_left, box_right, box_bottom, box_top, box_w, box_h;

  function automatic longint log2_q28(longint v);
    longint unsigned u, m;
    int e;
    longint f;
    f = 0;
    if (v < 1) v = 1;
    u = v;
    e = 0;
    while (e < 62 && (u >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (u >> (e - 30)) : (u << (30 - e));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | (64'sd1 << (LOG_FRAC - 1 - i));
      end
    end
    return (longint'(e) << LOG_FRAC) + f;
  endfunction

  // Mercator ordinate in Q28 via rotation and log2
  function automatic longint merc_ordinate(longint lat);
    longint mag, x, y, z, dx, dy, p, atn;
    bit neg;
    neg = lat < 0;
    mag = neg ? -lat : lat;
    if (mag > longint'(LAT_LIMIT)) mag = longint'(LAT_LIMIT);
    z = (mag * longint'(DEG_TO_RAD) + (64'sd1 << (ANGLE_FRAC_BITS + 1)))
        >>> (ANGLE_FRAC_BITS + 2);
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      atn = longint'(ATAN_Q30[i]);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atn;
      end else begin
        x = x + dx; y = y - dy; z = z + atn;
      end
    end
    p = log2_q28((64'sd1 << 30) + y) - log2_q28(x);
    return neg ? -p : p;
  endfunction

  // ceil(v)-1 for positive ratios, trunc otherwise
  function automatic longint ratio_pixel(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num > 0) return (num - 1) / den;
    return -((-num) / den);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] clamp_pixel(longint q, ref bit clip);
    longint lim;
    lim = 64'sd1 << (PIXEL_BITS - 1);
    if (q > lim - 1) begin q = lim - 1; clip = 1; end
    if (q < -lim) begin q = -lim; clip = 1; end
    return q[PIXEL_BITS-1:0];
  endfunction

  function automatic pixel_t project_vertex(logic [63:0] beat, logic last);
    pixel_t r;
    longint lon, lat, dx, dy, pb, qx, qy;
    bit clip;
    lon = longint'($signed(beat[LON_W-1:0]));
    lat = longint'($signed(beat[LON_W+LAT_W-1:LON_W]));
    clip = 0;
    qx = 0;
    qy = 0;
    dx = box_right - box_left;
    pb = merc_ordinate(box_bottom);
    dy = merc_ordinate(box_top) - pb;
    if (dx == 0) clip = 1;
    else qx = ratio_pixel((lon - box_left) * box_w, dx);
    if (dy == 0) clip = 1;
    else qy = ratio_pixel((merc_ordinate(lat) - pb) * box_h, dy);
    r.pix_x = clamp_pixel(qx, clip);
    r.pix_y = clamp_pixel(qy, clip);
    r.ring  = last;
    r.clip  = clip;
    return r;
  endfunction

  assign pixels_pending = pixel_q.size();

  // Track register writes
  always @(posedge clk) begin
    if (rst) begin
      box_left   <= -(64'sd180 << ANGLE_FRAC_BITS);
      box_right  <= 64'sd180 << ANGLE_FRAC_BITS;
      box_bottom <= -(64'sd85 << ANGLE_FRAC_BITS);
      box_top    <= 64'sd85 << ANGLE_FRAC_BITS;
      box_w      <= 1024;
      box_h      <= 1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LON_LEFT:   box_left   <= longint'($signed(cfg_data));
        REG_LON_RIGHT:  box_right  <= longint'($signed(cfg_data));
        REG_LAT_BOTTOM: box_bottom <= longint'($signed(cfg_data[LAT_W-1:0]));
        REG_LAT_TOP:    box_top    <= longint'($signed(cfg_data[LAT_W-1:0]));
        REG_WIN_WIDTH:  box_w      <= longint'(cfg_data[WIN_W-1:0]);
        REG_WIN_HEIGHT: box_h      <= longint'(cfg_data[WIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    pixel_t want, got;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (s_tvalid && s_tready) pixel_q.push_back(project_vertex(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        got.pix_x = m_tdata[15:0];
        got.pix_y = m_tdata[31:16];
        got.ring  = m_tlast;
        got.clip  = m_tuser;
        if (pixel_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected pixel beat: x=%0d y=%0d last=%b clip=%b",
                                        got.pix_x, got.pix_y, got.ring, got.clip);
          mismatches <= mismatches + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("pixel mismatch: exp x=%0d y=%0d last=%b clip=%b, got x=%0d y=%0d last=%b clip=%b",
                       want.pix_x, want.pix_y, want.ring, want.clip,
                       got.pix_x, got.pix_y, got.ring, got.clip);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
module tb_top import mpp_pkg::*;;

  localparam longint LON_MAX   = 754974720;
  localparam longint LAT_MAX   = 356725000;
  localparam int     CYCLE_CAP = 400000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [63:0]      s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;
  logic             m_tlast;
  logic             m_tuser;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [LON_W-1:0] cfg_data;

  int   pixels_pending;
  int   mismatches;
  int   cycles;
  int   hold_left;
  logic hold_kick;
  int   send_idle_pct;
  int   recv_stall_pct;

  mercator_point_to_pixel_top uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  mpp_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data, .pixels_pending, .mismatches
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Run-time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Receiver ready with random stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_left > 0) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic cfg_write(reg_index_t idx, longint value);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= value[LON_W-1:0];
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Offer one vertex beat, with an optional idle gap first
  task automatic send_vertex(longint lon, longint lat, logic last);
    logic [LAT_W-1:0] lat_bits;
    logic [LON_W-1:0] lon_bits;
    lat_bits = lat[LAT_W-1:0];
    lon_bits = lon[LON_W-1:0];
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {3'b000, lat_bits, lon_bits};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic void pick_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endfunction

  // Random vertices, idling pattern changes every 25 beats
  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) pick_idling($urandom_range(3));
      send_vertex(rand_lon(), rand_lat(), $urandom_range(7) == 0);
    end
  endtask

  // Drain and let the pipeline settle before touching registers
  task automatic drain();
    s_tvalid <= 0;
    while (pixels_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    rst            <= 1;
    s_tvalid       <= 0;
    s_tdata        <= '0;
    s_tlast        <= 0;
    cfg_we         <= 0;
    cfg_index      <= REG_LON_LEFT;
    cfg_data       <= '0;
    hold_kick      <= 0;
    cycles         <= 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset box: field extremes, box edges, ring ends
    send_vertex(-LON_MAX, -LAT_MAX, 0);
    send_vertex(LON_MAX, LAT_MAX, 1);
    send_vertex(0, 0, 0);
    send_vertex(-LON_MAX, LAT_MAX, 0);
    send_vertex(LON_MAX, -LAT_MAX, 1);
    send_vertex(-1, -1, 0);
    send_vertex(1, 1, 1);
    send_vertex(64'sd180 << 22, 64'sd85 << 22, 0);
    send_vertex(-(64'sd180 << 22), -(64'sd85 << 22), 1);
    send_vertex(64'sh3FFF_FFFF & LON_MAX, 64'sd100, 0);
    pick_idling(0);
    send_random(90);
    drain();

    // Widest box, largest window; long receiver hold-off while feeding
    cfg_write(REG_LON_LEFT, -LON_MAX);
    cfg_write(REG_LON_RIGHT, LON_MAX);
    cfg_write(REG_LAT_BOTTOM, -LAT_MAX);
    cfg_write(REG_LAT_TOP, LAT_MAX);
    cfg_write(REG_WIN_WIDTH, 8192);
    cfg_write(REG_WIN_HEIGHT, 8192);
    cfg_done();
    send_vertex(-LON_MAX, -LAT_MAX, 0);
    send_vertex(LON_MAX, LAT_MAX, 1);
    pick_idling(0);
    hold_kick <= 1;
    @(posedge clk);
    hold_kick <= 0;
    send_random(80);
    drain();

    // Small reversed box: mirrors the map and saturates
    cfg_write(REG_LON_LEFT, 64'sd10 << 22);
    cfg_write(REG_LON_RIGHT, 64'sd9 << 22);
    cfg_write(REG_LAT_BOTTOM, 64'sd50 << 22);
    cfg_write(REG_LAT_TOP, 64'sd40 << 22);
    cfg_done();
    send_vertex(64'sd10 << 22, 64'sd50 << 22, 0);
    send_vertex(64'sd9 << 22, 64'sd40 << 22, 1);
    send_random(80);
    drain();

    // Degenerate box, zero window size, ignored register indexes
    cfg_write(REG_LON_LEFT, 0);
    cfg_write(REG_LON_RIGHT, 0);
    cfg_write(REG_LAT_BOTTOM, -LAT_MAX);
    cfg_write(REG_LAT_TOP, -LAT_MAX);
    cfg_write(REG_WIN_WIDTH, 0);
    cfg_write(REG_WIN_HEIGHT, 0);
    cfg_write(reg_index_t'(3'd6), 123);
    cfg_write(reg_index_t'(3'd7), -1);
    cfg_done();
    send_vertex(0, -LAT_MAX, 1);
    send_random(40);
    drain();

    // Sized box at one pixel, then latitudes both at the clamp limit
    cfg_write(REG_LON_RIGHT, 64'sd5 << 22);
    cfg_write(REG_LAT_TOP, LAT_MAX);
    cfg_write(REG_WIN_WIDTH, 1);
    cfg_write(REG_WIN_HEIGHT, 1);
    cfg_done();
    send_random(40);
    drain();
    cfg_write(REG_LAT_BOTTOM, -(64'sd357 << 20));
    cfg_write(REG_LAT_TOP, -(64'sd357 << 20));
    cfg_done();
    send_random(20);
    drain();

    // Random boxes and window sizes
    for (int k = 0; k < 4; k++) begin
      cfg_write(REG_LON_LEFT, rand_lon());
      cfg_write(REG_LON_RIGHT, rand_lon());
      cfg_write(REG_LAT_BOTTOM, rand_lat());
      cfg_write(REG_LAT_TOP, rand_lat());
      cfg_write(REG_WIN_WIDTH, $urandom_range(1, 8192));
      cfg_write(REG_WIN_HEIGHT, $urandom_range(1, 8192));
      cfg_done();
      send_random(40);
      drain();
    end

    if (mismatches == 0 && pixels_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mpp_pkg.sv
rtl/mpp_cordic_cell.sv
rtl/mpp_log_cell.sv
rtl/mpp_div_cell.sv
rtl/mpp_merc.sv
rtl/mercator_point_to_pixel_top.sv
rtl/mpp_checker.sv
test/mpp_checker.sv
test/tb_top.sv
